// ===== src/qrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Holds the word formats, internal widths and the codes used across files.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // coefficient and root format
  localparam int COEF_W = 32;
  localparam int FRAC_W = 16;

  // configuration registers
  localparam int TOLC_W    = 16;
  localparam int TOLD_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_TOL = 2'd1;

  // internal widths
  localparam int MAG_W      = COEF_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int DISC_W     = PROD_W + 2;
  localparam int SQRT_W     = DISC_W / 2;
  localparam int SQRT_STEPS = SQRT_W;
  localparam int NUM_W      = SQRT_W + 1;
  localparam int DEN_W      = MAG_W + 1;
  localparam int N2_W       = NUM_W + FRAC_W + 2;
  localparam int D2_W       = DEN_W + 1;
  localparam int REMD_W     = D2_W + 1;
  localparam int Q_W        = COEF_W;
  localparam int OVF_W      = D2_W + Q_W;
  localparam int DIV_LAT    = Q_W + 2;

  // input to result, in clock cycles
  localparam int LATENCY = 4 + SQRT_STEPS + 1 + DIV_LAT + 1;

  // root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_INF,
    MODE_LIN,
    MODE_ONE,
    MODE_TWO
  } mode_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]               root_count;
    logic signed [COEF_W-1:0] root_first;
    logic signed [COEF_W-1:0] root_second;
    logic                     saturated;
  } qrs_out_t;

  // per-equation context carried alongside the square root
  typedef struct packed {
    mode_e            mode;
    logic             na;
    logic             nb;
    logic             nc;
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] mc;
  } ctx_t;

endpackage

// ===== src/qrs_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// Floor square root of the discriminant, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ctx_t              ctx_i,
  input  logic [DISC_W-1:0] rad_i,
  output logic              valid_o,
  output ctx_t              ctx_o,
  output logic [SQRT_W-1:0] root_o
);

  localparam int REM_W = SQRT_W + 3;
  localparam int RAD_W = 2 * SQRT_W;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [SQRT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

  // one restoring step: bring down two bits, try (root << 2) | 1
  function automatic sq_t sq_step(sq_t s);
    sq_t              r;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    rem2  = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[SQRT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[SQRT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [SQRT_STEPS-1:0] vld_q;
  sq_t                   st_q  [SQRT_STEPS];
  ctx_t                  ctx_q [SQRT_STEPS];
  sq_t                   init;

  always_comb begin
    init.rem  = '0;
    init.root = '0;
    init.rad  = RAD_W'(rad_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SQRT_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]  <= sq_step(init);
    ctx_q[0] <= ctx_i;
    for (int i = 1; i < SQRT_STEPS; i++) begin
      st_q[i]  <= sq_step(st_q[i-1]);
      ctx_q[i] <= ctx_q[i-1];
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign ctx_o   = ctx_q[SQRT_STEPS-1];
  assign root_o  = st_q[SQRT_STEPS-1].root;

endmodule

// ===== src/qrs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div: pipelined rounded, saturating root divider
// Computes round(num * 2^FRAC / den) ties away from zero, clamps, signs.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; (
  input  logic              clk_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              neg_i,
  output logic [COEF_W-1:0] quot_o,
  output logic              sat_o
);

  typedef struct packed {
    logic [REMD_W-1:0] rem;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    nlo;
    logic [D2_W-1:0]   d2;
    logic              neg;
    logic              ovf;
  } dv_t;

  // one restoring division step
  function automatic dv_t dv_step(dv_t s);
    dv_t               r;
    logic [REMD_W-1:0] rem2;
    r    = s;
    rem2 = {s.rem[REMD_W-2:0], s.nlo[Q_W-1]};
    r.nlo = {s.nlo[Q_W-2:0], 1'b0};
    if (rem2 >= REMD_W'(s.d2)) begin
      r.rem = rem2 - REMD_W'(s.d2);
      r.q   = {s.q[Q_W-2:0], 1'b1};
    end else begin
      r.rem = rem2;
      r.q   = {s.q[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [N2_W-1:0]  n2;
  logic [D2_W-1:0]  d2;
  dv_t              prep_d;
  dv_t              prep_q;
  dv_t              st_q [Q_W];
  logic [Q_W-1:0]   limit;
  logic             big;
  logic [Q_W-1:0]   qc;
  logic [COEF_W-1:0] quot_d;
  logic [COEF_W-1:0] quot_q;
  logic             sat_q;

  // numerator 2*num*2^FRAC + den over denominator 2*den
  always_comb begin
    n2         = N2_W'({num_i, {FRAC_W{1'b0}}, 1'b0}) + N2_W'(den_i);
    d2         = {den_i, 1'b0};
    prep_d.rem = REMD_W'(n2[N2_W-1:Q_W]);
    prep_d.q   = '0;
    prep_d.nlo = n2[Q_W-1:0];
    prep_d.d2  = d2;
    prep_d.neg = neg_i;
    prep_d.ovf = OVF_W'(n2) >= {d2, {Q_W{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    prep_q  <= prep_d;
    st_q[0] <= dv_step(prep_q);
    for (int i = 1; i < Q_W; i++) begin
      st_q[i] <= dv_step(st_q[i-1]);
    end
  end

  // clamp to the signed range, then apply the sign
  always_comb begin
    limit  = st_q[Q_W-1].neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    big    = st_q[Q_W-1].ovf || (st_q[Q_W-1].q > limit);
    qc     = big ? limit : st_q[Q_W-1].q;
    quot_d = st_q[Q_W-1].neg ? COEF_W'(Q_W'(0) - qc) : COEF_W'(qc);
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    sat_q  <= big;
  end

  assign quot_o = quot_q;
  assign sat_o  = sat_q;

endmodule

// ===== src/quadratic_root_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c = 0 in Q16.16
// Fully pipelined solver with configurable near-zero tolerances.
// ----------------------------------------------------------------------------
// The solver takes one equation word in every clock cycle (busy_o is never
// raised) and shows its result word from the output register for a
// single cycle on result_o, marked by result_valid_o; the receiver cannot
// stall it, so capture the result in that cycle. The latency is set by the
// 33-stage square root (one root bit per stage) and the 34-stage dividers
// (one quotient bit per stage, plus setup and clamp), with six more register
// stages for decode, multiply, discriminant, classification, numerator setup
// and the output word. Write the tolerance registers only while no equation is
// in flight; cfg_ready_o is always high and an unknown index is dropped.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  qrs_in_t              in_i,
  output logic                 result_valid_o,
  output qrs_out_t             result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
  } sm_t;

  // magnitude of a two's complement coefficient
  function automatic logic [MAG_W-1:0] mag_of(logic [COEF_W-1:0] v);
    return v[COEF_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
  endfunction

  // signed-magnitude addition
  function automatic sm_t sm_add(logic xn, logic [NUM_W-1:0] xm,
                                 logic yn, logic [NUM_W-1:0] ym);
    sm_t r;
    if (xn == yn) begin
      r.neg = xn;
      r.mag = xm + ym;
    end else if (xm >= ym) begin
      r.neg = xn;
      r.mag = xm - ym;
    end else begin
      r.neg = yn;
      r.mag = ym - xm;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TOLC_W-1:0] coef_tol_q;
  logic [TOLD_W-1:0] disc_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_tol_q <= '0;
      disc_tol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COEF_TOL: coef_tol_q <= cfg_data_i[TOLC_W-1:0];
        REG_DISC_TOL: disc_tol_q <= cfg_data_i[TOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: split coefficients into sign and magnitude
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  ctx_t s1_ctx_d, s1_ctx_q;

  always_comb begin
    s1_ctx_d.mode = MODE_NONE;
    s1_ctx_d.na   = in_i.coef_a[COEF_W-1];
    s1_ctx_d.nb   = in_i.coef_b[COEF_W-1];
    s1_ctx_d.nc   = in_i.coef_c[COEF_W-1];
    s1_ctx_d.ma   = mag_of(in_i.coef_a);
    s1_ctx_d.mb   = mag_of(in_i.coef_b);
    s1_ctx_d.mc   = mag_of(in_i.coef_c);
  end

  // --------------------------------------------------------------------------
  // Stage 2: b*b and a*c, near-zero tests on the coefficients
  // --------------------------------------------------------------------------
  logic              s2_valid_q;
  ctx_t              s2_ctx_q;
  logic [PROD_W-1:0] s2_bb_q, s2_ac_q;
  logic [PROD_W-1:0] bb_d, ac_d;
  logic              s2_asm_q, s2_bsm_q, s2_csm_q;

  assign bb_d = s1_ctx_q.mb * s1_ctx_q.mb;
  assign ac_d = s1_ctx_q.ma * s1_ctx_q.mc;

  // --------------------------------------------------------------------------
  // Stage 3: discriminant b*b - 4*a*c in sign and magnitude
  // --------------------------------------------------------------------------
  logic              s3_valid_q;
  ctx_t              s3_ctx_q;
  logic              s3_asm_q, s3_bsm_q, s3_csm_q;
  logic [DISC_W-1:0] s3_dmag_q, dmag_d, bbx, fac;
  logic              s3_dneg_q, dneg_d;

  always_comb begin
    bbx = DISC_W'(s2_bb_q);
    fac = {s2_ac_q, 2'b00};
    if (s2_ctx_q.na != s2_ctx_q.nc) begin
      dneg_d = 1'b0;
      dmag_d = bbx + fac;
    end else if (bbx >= fac) begin
      dneg_d = 1'b0;
      dmag_d = bbx - fac;
    end else begin
      dneg_d = 1'b1;
      dmag_d = fac - bbx;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: classify the equation
  // --------------------------------------------------------------------------
  logic              s4_valid_q;
  ctx_t              s4_ctx_q, s4_ctx_d;
  logic [DISC_W-1:0] s4_dmag_q;

  always_comb begin
    s4_ctx_d = s3_ctx_q;
    if (s3_asm_q) begin
      if (s3_bsm_q) begin
        s4_ctx_d.mode = s3_csm_q ? MODE_INF : MODE_NONE;
      end else begin
        s4_ctx_d.mode = MODE_LIN;
      end
    end else if (s3_dmag_q <= DISC_W'(disc_tol_q)) begin
      // tolerance test first: a small negative discriminant also gives one root
      s4_ctx_d.mode = MODE_ONE;
    end else if (!s3_dneg_q) begin
      s4_ctx_d.mode = MODE_TWO;
    end else begin
      s4_ctx_d.mode = MODE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctx_q  <= s1_ctx_d;
    s2_ctx_q  <= s1_ctx_q;
    s2_bb_q   <= bb_d;
    s2_ac_q   <= ac_d;
    s2_asm_q  <= s1_ctx_q.ma <= MAG_W'(coef_tol_q);
    s2_bsm_q  <= s1_ctx_q.mb <= MAG_W'(coef_tol_q);
    s2_csm_q  <= s1_ctx_q.mc <= MAG_W'(coef_tol_q);
    s3_ctx_q  <= s2_ctx_q;
    s3_asm_q  <= s2_asm_q;
    s3_bsm_q  <= s2_bsm_q;
    s3_csm_q  <= s2_csm_q;
    s3_dmag_q <= dmag_d;
    s3_dneg_q <= dneg_d;
    s4_ctx_q  <= s4_ctx_d;
    s4_dmag_q <= s3_dmag_q;
  end

  // --------------------------------------------------------------------------
  // Square root of the discriminant
  // --------------------------------------------------------------------------
  logic              sq_valid;
  ctx_t              sq_ctx;
  logic [SQRT_W-1:0] sq_root;

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_valid_q),
    .ctx_i   (s4_ctx_q),
    .rad_i   (s4_dmag_q),
    .valid_o (sq_valid),
    .ctx_o   (sq_ctx),
    .root_o  (sq_root)
  );

  // --------------------------------------------------------------------------
  // Stage 5: numerators and denominator for both dividers
  // --------------------------------------------------------------------------
  logic             s5_valid_q;
  mode_e            s5_mode_q;
  logic [NUM_W-1:0] s5_num1_q, s5_num2_q;
  logic [DEN_W-1:0] s5_den_q, den_d;
  logic             s5_neg1_q, s5_neg2_q;
  sm_t              n1_d, n2_d, lo_sm, hi_sm;
  logic             dsgn;

  always_comb begin
    lo_sm = sm_add(!sq_ctx.nb, NUM_W'(sq_ctx.mb), 1'b1, NUM_W'(sq_root));
    hi_sm = sm_add(!sq_ctx.nb, NUM_W'(sq_ctx.mb), 1'b0, NUM_W'(sq_root));
    case (sq_ctx.mode)
      MODE_LIN: begin
        n1_d.neg = !sq_ctx.nc;
        n1_d.mag = NUM_W'(sq_ctx.mc);
        n2_d     = n1_d;
        den_d    = DEN_W'(sq_ctx.mb);
        dsgn     = sq_ctx.nb;
      end
      MODE_TWO: begin
        n1_d  = lo_sm;
        n2_d  = hi_sm;
        den_d = {sq_ctx.ma, 1'b0};
        dsgn  = sq_ctx.na;
      end
      default: begin
        n1_d.neg = !sq_ctx.nb;
        n1_d.mag = NUM_W'(sq_ctx.mb);
        n2_d     = n1_d;
        den_d    = {sq_ctx.ma, 1'b0};
        dsgn     = sq_ctx.na;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_mode_q <= sq_ctx.mode;
    s5_num1_q <= n1_d.mag;
    s5_num2_q <= n2_d.mag;
    s5_neg1_q <= n1_d.neg ^ dsgn;
    s5_neg2_q <= n2_d.neg ^ dsgn;
    s5_den_q  <= den_d;
  end

  // --------------------------------------------------------------------------
  // Dividers, with the valid bit and mode delayed to match
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0]  q1, q2;
  logic               sat1, sat2;
  logic [DIV_LAT-1:0] dl_vld_q;
  mode_e              dl_mode_q [DIV_LAT];

  qrs_div u_div_first (
    .clk_i  (clk_i),
    .num_i  (s5_num1_q),
    .den_i  (s5_den_q),
    .neg_i  (s5_neg1_q),
    .quot_o (q1),
    .sat_o  (sat1)
  );

  qrs_div u_div_second (
    .clk_i  (clk_i),
    .num_i  (s5_num2_q),
    .den_i  (s5_den_q),
    .neg_i  (s5_neg2_q),
    .quot_o (q2),
    .sat_o  (sat2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q <= '0;
    end else begin
      dl_vld_q <= {dl_vld_q[DIV_LAT-2:0], s5_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    dl_mode_q[0] <= s5_mode_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      dl_mode_q[i] <= dl_mode_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output word: pick roots by mode, zero the unused ones
  // --------------------------------------------------------------------------
  logic     result_valid_q;
  qrs_out_t result_d, result_q;

  always_comb begin
    result_d = '0;
    case (dl_mode_q[DIV_LAT-1])
      MODE_INF: begin
        result_d.root_count = CNT_INF;
      end
      MODE_LIN: begin
        result_d.root_count = CNT_ONE;
        result_d.root_first = q1;
        result_d.saturated  = sat1;
      end
      MODE_ONE: begin
        result_d.root_count  = CNT_ONE;
        result_d.root_first  = q1;
        result_d.root_second = q1;
        result_d.saturated   = sat1;
      end
      MODE_TWO: begin
        result_d.root_count  = CNT_TWO;
        result_d.root_first  = q1;
        result_d.root_second = q2;
        result_d.saturated   = sat1 | sat2;
      end
      default: begin
        result_d.root_count = CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= dl_vld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ===== src/qrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker: port-level checks for the quadratic root solver
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module qrs_checker import qrs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     result_valid_o,
  input qrs_out_t result_o
);

  localparam logic [COEF_W-1:0] ROOT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] ROOT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // every result word comes from a word accepted a fixed latency earlier
  a_result_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result word without matching accepted word");

  // no roots or infinitely many: roots and flag read zero
  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.root_count == CNT_NONE ||
                       result_o.root_count == CNT_INF)
    |-> result_o.root_first == '0 && result_o.root_second == '0 &&
        !result_o.saturated)
    else $error("root fields not zero without finite roots");

  // a clamped root sits at one end of the range
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.saturated
    |-> result_o.root_first == ROOT_MAX || result_o.root_first == ROOT_MIN ||
        result_o.root_second == ROOT_MAX || result_o.root_second == ROOT_MIN)
    else $error("saturated flag without a clamped root");

  // a single root leaves the second root at zero (linear) or equal to the first (double)
  a_one_root_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.root_count == CNT_ONE
    |-> result_o.root_second == '0 || result_o.root_second == result_o.root_first)
    else $error("single root with stray second root");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
